[rtl/esdd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esdd_pkg
// Shared types and constants for the EBCDIC SO/SI mixed-byte decoder.
// ----------------------------------------------------------------------------
package esdd_pkg;

  localparam int SINGLE_DEPTH = 256;
  localparam int PAIR_DEPTH   = 65536;
  localparam int SINGLE_AW    = $clog2(SINGLE_DEPTH);
  localparam int PAIR_AW      = $clog2(PAIR_DEPTH);

  localparam logic [7:0]  BYTE_SO   = 8'h0E;
  localparam logic [7:0]  BYTE_SI   = 8'h0F;
  localparam logic [15:0] NO_MAP    = 16'hFFFD;
  localparam logic [7:0]  HOST_LO   = 8'h41;
  localparam logic [7:0]  HOST_HI   = 8'hFE;
  localparam logic [7:0]  HOST_PAD  = 8'h40;

  localparam logic [7:0]  TRAIL_MIN_RST = 8'h40;
  localparam logic [7:0]  TRAIL_MAX_RST = 8'hFE;
  localparam logic [15:0] REPL_RST      = 16'hFFFD;

  localparam logic [1:0]  LEN_NONE = 2'd0;
  localparam logic [1:0]  LEN_ONE  = 2'd1;
  localparam logic [1:0]  LEN_TWO  = 2'd2;

  typedef enum logic [1:0] {
    CMD_DECODE   = 2'd0,
    CMD_WR_SINGLE = 2'd1,
    CMD_WR_PAIR  = 2'd2,
    CMD_END      = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_CHAR       = 2'd0,
    ST_MALFORMED  = 2'd1,
    ST_UNMAPPABLE = 2'd2,
    ST_INCOMPLETE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_TRAIL_MIN = 2'd0,
    CFG_TRAIL_MAX = 2'd1,
    CFG_REPL      = 2'd2,
    CFG_SUBST     = 2'd3
  } cfg_idx_e;

  // What the lookup stage has to do with the request in flight
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_SINGLE = 2'd1,
    OP_PAIR   = 2'd2,
    OP_ERR    = 2'd3
  } op_e;

  typedef struct packed {
    logic [7:0]  trail_min;
    logic [7:0]  trail_max;
    logic [15:0] repl;
    logic        subst;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    op_e        op;
    status_e    status;
    logic [1:0] len;
    logic       pair_ok;
    logic       host;
  } lkp_t;

  typedef struct packed {
    logic [15:0] char_code;
    status_e     status;
    logic [1:0]  error_length;
  } res_t;

endpackage

`default_nettype wire

[rtl/esdd_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esdd_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module esdd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/esdd_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esdd_front
// Shift state tracking, request decode and table access issue.
// ----------------------------------------------------------------------------
module esdd_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire esdd_pkg::cmd_e              cmd_i,
  input  wire logic [7:0]                  byte_i,
  input  wire logic [15:0]                 index_i,
  input  wire logic [15:0]                 value_i,
  input  wire esdd_pkg::cfg_t              cfg_i,
  output logic                             sgl_en_o,
  output logic                             sgl_we_o,
  output logic [esdd_pkg::SINGLE_AW-1:0]   sgl_addr_o,
  output logic                             pair_en_o,
  output logic                             pair_we_o,
  output logic [esdd_pkg::PAIR_AW-1:0]     pair_addr_o,
  output logic [15:0]                      wdata_o,
  output esdd_pkg::lkp_t                   lkp_o
);

  logic          shift_q, shift_d;
  logic          pend_q, pend_d;
  logic [7:0]    lead_q, lead_d;
  esdd_pkg::lkp_t lkp_q, lkp_d;

  logic [15:0] pidx;
  logic        pidx_in;
  logic        trail_in;
  logic        host;

  assign pidx     = {lead_q, byte_i};
  assign pidx_in  = {1'b0, pidx} < 17'(esdd_pkg::PAIR_DEPTH);
  assign trail_in = (byte_i >= cfg_i.trail_min) && (byte_i <= cfg_i.trail_max);
  assign host = (lead_q >= esdd_pkg::HOST_LO && lead_q <= esdd_pkg::HOST_HI &&
                 byte_i >= esdd_pkg::HOST_LO && byte_i <= esdd_pkg::HOST_HI) ||
                (lead_q == esdd_pkg::HOST_PAD && byte_i == esdd_pkg::HOST_PAD);

  always_comb begin
    shift_d     = shift_q;
    pend_d      = pend_q;
    lead_d      = lead_q;
    lkp_d       = '0;
    lkp_d.op    = esdd_pkg::OP_NONE;
    lkp_d.status = esdd_pkg::ST_CHAR;
    sgl_en_o    = 1'b0;
    sgl_we_o    = 1'b0;
    pair_en_o   = 1'b0;
    pair_we_o   = 1'b0;
    sgl_addr_o  = byte_i;
    pair_addr_o = pidx[esdd_pkg::PAIR_AW-1:0];
    wdata_o     = value_i;

    unique case (cmd_i)
      esdd_pkg::CMD_WR_SINGLE: begin
        sgl_addr_o = index_i[esdd_pkg::SINGLE_AW-1:0];
        sgl_we_o   = index_i[15:esdd_pkg::SINGLE_AW] == '0;
        sgl_en_o   = sgl_we_o;
      end
      esdd_pkg::CMD_WR_PAIR: begin
        pair_addr_o = index_i[esdd_pkg::PAIR_AW-1:0];
        pair_we_o   = {1'b0, index_i} < 17'(esdd_pkg::PAIR_DEPTH);
        pair_en_o   = pair_we_o;
      end
      esdd_pkg::CMD_END: begin
        if (pend_q) begin
          lkp_d.op     = esdd_pkg::OP_ERR;
          lkp_d.status = esdd_pkg::ST_INCOMPLETE;
          lkp_d.len    = esdd_pkg::LEN_ONE;
        end
        shift_d = 1'b0;
        pend_d  = 1'b0;
      end
      esdd_pkg::CMD_DECODE: begin
        if (pend_q) begin
          // trail byte, shift codes included
          pend_d        = 1'b0;
          lkp_d.op      = esdd_pkg::OP_PAIR;
          lkp_d.pair_ok = trail_in && pidx_in;
          lkp_d.host    = host;
          pair_en_o     = trail_in && pidx_in;
        end else if (byte_i == esdd_pkg::BYTE_SO) begin
          if (shift_q) begin
            lkp_d.op     = esdd_pkg::OP_ERR;
            lkp_d.status = esdd_pkg::ST_MALFORMED;
            lkp_d.len    = esdd_pkg::LEN_ONE;
          end else begin
            shift_d = 1'b1;
          end
        end else if (byte_i == esdd_pkg::BYTE_SI) begin
          if (!shift_q) begin
            lkp_d.op     = esdd_pkg::OP_ERR;
            lkp_d.status = esdd_pkg::ST_MALFORMED;
            lkp_d.len    = esdd_pkg::LEN_ONE;
          end else begin
            shift_d = 1'b0;
          end
        end else if (!shift_q) begin
          lkp_d.op = esdd_pkg::OP_SINGLE;
          sgl_en_o = 1'b1;
        end else begin
          lead_d = byte_i;
          pend_d = 1'b1;
        end
      end
      default: ;
    endcase

    lkp_d.valid = accept_i && (lkp_d.op != esdd_pkg::OP_NONE);

    if (!accept_i) begin
      shift_d   = shift_q;
      pend_d    = pend_q;
      lead_d    = lead_q;
      sgl_en_o  = 1'b0;
      sgl_we_o  = 1'b0;
      pair_en_o = 1'b0;
      pair_we_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 1'b0;
      pend_q  <= 1'b0;
      lead_q  <= '0;
      lkp_q   <= '0;
    end else begin
      shift_q <= shift_d;
      pend_q  <= pend_d;
      lead_q  <= lead_d;
      lkp_q   <= lkp_d;
    end
  end

  assign lkp_o = lkp_q;

endmodule

`default_nettype wire

[rtl/esdd_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esdd_back
// Table data check, error/replacement selection and two-entry output queue.
// ----------------------------------------------------------------------------
module esdd_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire esdd_pkg::lkp_t lkp_i,
  input  wire logic [15:0]    sgl_rdata_i,
  input  wire logic [15:0]    pair_rdata_i,
  input  wire esdd_pkg::cfg_t cfg_i,
  input  wire logic           out_ready_i,
  output logic                out_valid_o,
  output esdd_pkg::res_t      out_o,
  output logic                in_ready_o
);

  logic [15:0]       code;
  logic              err;
  esdd_pkg::status_e err_st;
  logic [1:0]        err_len;
  esdd_pkg::res_t    res;

  esdd_pkg::res_t fifo_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q, cnt_d;
  logic           push, pop;
  logic [1:0]     occ;

  always_comb begin
    code    = sgl_rdata_i;
    err     = 1'b0;
    err_st  = esdd_pkg::ST_CHAR;
    err_len = esdd_pkg::LEN_NONE;
    case (lkp_i.op)
      esdd_pkg::OP_SINGLE: begin
        code    = sgl_rdata_i;
        err     = sgl_rdata_i == esdd_pkg::NO_MAP;
        err_st  = esdd_pkg::ST_UNMAPPABLE;
        err_len = esdd_pkg::LEN_ONE;
      end
      esdd_pkg::OP_PAIR: begin
        // out-of-range trail reads as NO_MAP: unmappable for a host pair, else malformed
        code    = lkp_i.pair_ok ? pair_rdata_i : esdd_pkg::NO_MAP;
        err     = code == esdd_pkg::NO_MAP;
        err_st  = lkp_i.host ? esdd_pkg::ST_UNMAPPABLE : esdd_pkg::ST_MALFORMED;
        err_len = esdd_pkg::LEN_TWO;
      end
      esdd_pkg::OP_ERR: begin
        err     = 1'b1;
        err_st  = lkp_i.status;
        err_len = lkp_i.len;
      end
      default: ;
    endcase

    res.char_code    = code;
    res.status       = esdd_pkg::ST_CHAR;
    res.error_length = esdd_pkg::LEN_NONE;
    if (err) begin
      if (cfg_i.subst) begin
        res.char_code = cfg_i.repl;
      end else begin
        res.char_code    = '0;
        res.status       = err_st;
        res.error_length = err_len;
      end
    end
  end

  // Slots are reserved at accept time, so a push always finds room
  assign push        = lkp_i.valid;
  assign out_valid_o = cnt_q != 2'd0;
  assign pop         = out_valid_o && out_ready_i;
  assign out_o       = fifo_q[rptr_q];
  assign occ         = cnt_q + {1'b0, lkp_i.valid};
  assign in_ready_o  = (occ < 2'd2) || pop;

  always_comb begin
    cnt_d = cnt_q;
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= res;
    end
  end

endmodule

`default_nettype wire

[rtl/ebcdic_shift_dbcs_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted request and its table read are registered together, and the result
// is then written into the output queue, which raises m_axis_tvalid.
// Throughput: one request per cycle unless stalled; each decoded character needs at most
// one read of the single or pair table RAM, and table writes use the same port in their own cycle.
// Input stalls only while the two-entry result queue is spoken for.
// Reset: shift state, held lead and queue clear and config registers load their
// reset values at once; the tables are not cleared and hold nothing defined until written.
// ----------------------------------------------------------------------------
// ebcdic_shift_dbcs_decoder
// Mixed EBCDIC single/double-byte decoder with shift-out / shift-in control.
// ----------------------------------------------------------------------------
module ebcdic_shift_dbcs_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] byte_value, [23:8] table_index, [39:24] table_value
  input  wire logic [39:0] s_axis_tdata,
  // [1:0] command
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [15:0] char_code, [17:16] error_length, [23:18] zero
  output logic [23:0]      m_axis_tdata,
  // [1:0] status
  output logic [1:0]       m_axis_tuser,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  esdd_pkg::cfg_t cfg_q;
  esdd_pkg::lkp_t lkp;
  esdd_pkg::res_t res;

  logic                           accept;
  logic                           sgl_en, sgl_we, pair_en, pair_we;
  logic [esdd_pkg::SINGLE_AW-1:0] sgl_addr;
  logic [esdd_pkg::PAIR_AW-1:0]   pair_addr;
  logic [15:0]                    wdata, sgl_rdata, pair_rdata;

  assign cfg_ready_o = 1'b1;
  assign accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trail_min <= esdd_pkg::TRAIL_MIN_RST;
      cfg_q.trail_max <= esdd_pkg::TRAIL_MAX_RST;
      cfg_q.repl      <= esdd_pkg::REPL_RST;
      cfg_q.subst     <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (esdd_pkg::cfg_idx_e'(cfg_index_i))
        esdd_pkg::CFG_TRAIL_MIN: cfg_q.trail_min <= cfg_data_i[7:0];
        esdd_pkg::CFG_TRAIL_MAX: cfg_q.trail_max <= cfg_data_i[7:0];
        esdd_pkg::CFG_REPL:      cfg_q.repl      <= cfg_data_i;
        esdd_pkg::CFG_SUBST:     cfg_q.subst     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  esdd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .cmd_i       (esdd_pkg::cmd_e'(s_axis_tuser)),
    .byte_i      (s_axis_tdata[7:0]),
    .index_i     (s_axis_tdata[23:8]),
    .value_i     (s_axis_tdata[39:24]),
    .cfg_i       (cfg_q),
    .sgl_en_o    (sgl_en),
    .sgl_we_o    (sgl_we),
    .sgl_addr_o  (sgl_addr),
    .pair_en_o   (pair_en),
    .pair_we_o   (pair_we),
    .pair_addr_o (pair_addr),
    .wdata_o     (wdata),
    .lkp_o       (lkp)
  );

  esdd_ram #(
    .WIDTH (16),
    .DEPTH (esdd_pkg::SINGLE_DEPTH)
  ) u_single_ram (
    .clk_i   (clk_i),
    .en_i    (sgl_en),
    .we_i    (sgl_we),
    .addr_i  (sgl_addr),
    .wdata_i (wdata),
    .rdata_o (sgl_rdata)
  );

  esdd_ram #(
    .WIDTH (16),
    .DEPTH (esdd_pkg::PAIR_DEPTH)
  ) u_pair_ram (
    .clk_i   (clk_i),
    .en_i    (pair_en),
    .we_i    (pair_we),
    .addr_i  (pair_addr),
    .wdata_i (wdata),
    .rdata_o (pair_rdata)
  );

  esdd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .lkp_i        (lkp),
    .sgl_rdata_i  (sgl_rdata),
    .pair_rdata_i (pair_rdata),
    .cfg_i        (cfg_q),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_o        (res),
    .in_ready_o   (s_axis_tready)
  );

  assign m_axis_tdata = {6'b0, res.error_length, res.char_code};
  assign m_axis_tuser = res.status;

endmodule

`default_nettype wire

[rtl/esdd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esdd_checker
// Port-level checks for the mixed-byte decoder, bound to the top level.
// ----------------------------------------------------------------------------
module esdd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  // A plain character never carries an error length
  a_char_no_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == esdd_pkg::ST_CHAR) |->
      m_axis_tdata[17:16] == esdd_pkg::LEN_NONE)
    else $error("character result with nonzero error length");

  // Reported errors zero the character
  a_err_zero_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != esdd_pkg::ST_CHAR) |->
      m_axis_tdata[15:0] == 16'h0000)
    else $error("error result with nonzero character");

  // Incomplete pair covers one byte; other errors one or two
  a_err_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != esdd_pkg::ST_CHAR) |->
      ((m_axis_tuser == esdd_pkg::ST_INCOMPLETE &&
        m_axis_tdata[17:16] == esdd_pkg::LEN_ONE) ||
       (m_axis_tuser != esdd_pkg::ST_INCOMPLETE &&
        (m_axis_tdata[17:16] == esdd_pkg::LEN_ONE ||
         m_axis_tdata[17:16] == esdd_pkg::LEN_TWO))))
    else $error("error length does not match status");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind ebcdic_shift_dbcs_decoder esdd_checker u_esdd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
